// File: rtl/core/bfr_pkg.sv
// Package for the bitstream field reader: sizes, request and status codes,
// controller state type. Used by bitstream_field_reader and its testbench.
package bfr_pkg;

   localparam int BUF_BYTES    = 4096;
   localparam int SAVE_SLOTS   = 16;
   localparam int MAX_UE_ZEROS = 31;

   localparam int ADDR_W   = $clog2(BUF_BYTES);
   localparam int BUF_BITS = BUF_BYTES * 8;
   localparam int SLOT_W   = (SAVE_SLOTS > 1) ? $clog2(SAVE_SLOTS) : 1;
   localparam int POS_W    = 19;
   localparam int RPOS_W   = POS_W + 1;
   localparam int ZERO_W   = 6;

   typedef enum logic [3:0] {
      OP_WRITE     = 4'd0,
      OP_BITS      = 4'd1,
      OP_UE        = 4'd2,
      OP_SE        = 4'd3,
      OP_ALIGN     = 4'd4,
      OP_BYTES     = 4'd5,
      OP_SKIPBITS  = 4'd6,
      OP_SKIPBYTES = 4'd7,
      OP_SAVE      = 4'd8,
      OP_RESTORE   = 4'd9,
      OP_CLEAR     = 4'd10,
      OP_QUERY     = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_ID  = 2'd1,
      ST_UE_LONG = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic {
      CSR_BYTE_ORDER  = 1'b0,
      CSR_DATA_LENGTH = 1'b1
   } csr_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EXEC   = 7'b0000010,
      S_LOAD   = 7'b0000100,
      S_BIT    = 7'b0001000,
      S_PAD    = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

endpackage

// File: rtl/core/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: rtl/core/bitstream_field_reader.sv
// Bitstream field reader top level: byte buffer, position, save slots, bit-serial reader.
// Depends on bfr_pkg and bfr_ram.
// Requests that move no data pass S_EXEC and S_DONE only; reads step S_LOAD and S_BIT per bit
// (buffer RAM read port, one bit per access) and then S_FINISH, and little-endian byte reads
// add an S_PAD step per missing byte. One word at a time; the next word is taken while a
// result waits. Synchronous reset clears position, save valid bits, id counter, config.
module bitstream_field_reader (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_type,
   input  logic [12:0]        req_count,
   input  logic [11:0]        req_write_address,
   input  logic [7:0]         req_write_byte,
   input  logic [15:0]        req_save_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_value,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_new_save_id,
   output logic [15:0]        rsp_consumed_bytes,
   output logic               rsp_available,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [12:0]        csr_wdata
);
   bfr_pkg::state_type state_ff, state_in;
   bfr_pkg::op_type    op_ff;
   logic [12:0] count_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wbyte_ff;
   logic [15:0] sid_ff;
   logic [bfr_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [bfr_pkg::RPOS_W-1:0] rd_pos_ff, rd_pos_in;
   logic [6:0]  remain_ff, remain_in;
   logic [bfr_pkg::ZERO_W-1:0] zeros_ff, zeros_in;
   logic        suffix_ff, suffix_in;
   logic [2:0]  pad_ff, pad_in;
   logic [7:0]  byte_ff, byte_in;
   logic [63:0] value_ff, value_in;
   bfr_pkg::status_type status_ff, status_in;
   logic [15:0] newid_ff, newid_in;
   logic        avail_ff, avail_in;
   logic [15:0] next_id_ff, next_id_in;
   logic [bfr_pkg::POS_W-1:0] slot_pos_ff [bfr_pkg::SAVE_SLOTS];
   logic [15:0] slot_id_ff [bfr_pkg::SAVE_SLOTS];
   logic [bfr_pkg::SAVE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic        slot_we;
   logic        big_ff;
   logic [12:0] len_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_newid_ff, rsp_consumed_ff;
   logic        rsp_avail_ff;

   logic [bfr_pkg::ADDR_W-1:0] ram_raddr;
   logic [7:0]  ram_rdata;
   logic        ram_we;
   logic        cur_bit;
   logic [6:0]  nbits;
   logic [bfr_pkg::SLOT_W-1:0] slot_save, slot_req;
   logic [16:0] consumed;
   logic [20:0] end_pos;
   logic        byte_cnt_ok;
   logic [2:0]  pad_cnt;
   logic [3:0]  pad_full;

   assign req_ready = (state_ff == bfr_pkg::S_IDLE);
   assign ram_raddr = rd_pos_ff[bfr_pkg::ADDR_W+2:3];
   assign ram_we    = (state_ff == bfr_pkg::S_EXEC) && (op_ff == bfr_pkg::OP_WRITE)
                      && (32'(addr_ff) < bfr_pkg::BUF_BYTES);
   assign cur_bit   = ram_rdata[3'd7 - rd_pos_ff[2:0]];
   assign slot_save = next_id_ff[bfr_pkg::SLOT_W-1:0];
   assign slot_req  = sid_ff[bfr_pkg::SLOT_W-1:0];
   assign consumed  = {1'b0, pos_ff[18:3]} + {16'd0, |pos_ff[2:0]};
   assign byte_cnt_ok = (count_ff == 13'd1) || (count_ff == 13'd2) || (count_ff == 13'd4)
                        || (count_ff == 13'd8);
   assign pad_full  = 4'd8 - count_ff[3:0];
   assign pad_cnt   = pad_full[2:0];

   always_comb begin
      if (op_ff == bfr_pkg::OP_BYTES) begin
         nbits = {count_ff[3:0], 3'b000};
      end else if (count_ff > 13'd64) begin
         nbits = 7'd64;
      end else begin
         nbits = count_ff[6:0];
      end
   end
   assign end_pos = {2'b00, pos_ff} + {14'd0, nbits};

   bfr_ram #(.WIDTH(8), .DEPTH(bfr_pkg::BUF_BYTES)) u_buf (
      .clock (clock),
      .we    (ram_we),
      .waddr (bfr_pkg::ADDR_W'(addr_ff)),
      .wdata (wbyte_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      rd_pos_in     = rd_pos_ff;
      remain_in     = remain_ff;
      zeros_in      = zeros_ff;
      suffix_in     = suffix_ff;
      pad_in        = pad_ff;
      byte_in       = byte_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      newid_in      = newid_ff;
      avail_in      = avail_ff;
      next_id_in    = next_id_ff;
      slot_valid_in = slot_valid_ff;
      slot_we       = 1'b0;
      unique case (state_ff)
         bfr_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in  = bfr_pkg::S_EXEC;
               value_in  = '0;
               status_in = bfr_pkg::ST_OK;
               newid_in  = '0;
               avail_in  = 1'b0;
            end
         end
         bfr_pkg::S_EXEC: begin
            state_in  = bfr_pkg::S_DONE;
            rd_pos_in = {1'b0, pos_ff};
            remain_in = nbits;
            zeros_in  = '0;
            suffix_in = 1'b0;
            pad_in    = pad_cnt;
            unique case (op_ff)
               bfr_pkg::OP_BITS: begin
                  if (end_pos > 21'(bfr_pkg::BUF_BITS)) begin
                     status_in = bfr_pkg::ST_RANGE;
                  end else if (nbits == 7'd0) begin
                     state_in = bfr_pkg::S_FINISH;
                  end else begin
                     state_in = bfr_pkg::S_LOAD;
                  end
               end
               bfr_pkg::OP_UE, bfr_pkg::OP_SE: begin
                  state_in = bfr_pkg::S_LOAD;
               end
               bfr_pkg::OP_BYTES: begin
                  if (byte_cnt_ok) begin
                     if (end_pos > 21'(bfr_pkg::BUF_BITS)) begin
                        status_in = bfr_pkg::ST_RANGE;
                     end else begin
                        state_in = bfr_pkg::S_LOAD;
                     end
                  end
               end
               bfr_pkg::OP_ALIGN: begin
                  if (pos_ff[2:0] != 3'd0) begin
                     pos_in = {pos_ff[18:3] + 16'd1, 3'b000};
                  end
               end
               bfr_pkg::OP_SKIPBITS: begin
                  pos_in = pos_ff + {6'd0, count_ff};
               end
               bfr_pkg::OP_SKIPBYTES: begin
                  pos_in = pos_ff + {3'd0, count_ff, 3'b000};
               end
               bfr_pkg::OP_SAVE: begin
                  slot_we                  = 1'b1;
                  slot_valid_in[slot_save] = 1'b1;
                  newid_in                 = next_id_ff;
                  next_id_in               = next_id_ff + 16'd1;
               end
               bfr_pkg::OP_RESTORE, bfr_pkg::OP_CLEAR: begin
                  if (!slot_valid_ff[slot_req] || (slot_id_ff[slot_req] != sid_ff)) begin
                     status_in = bfr_pkg::ST_BAD_ID;
                  end else if (op_ff == bfr_pkg::OP_RESTORE) begin
                     pos_in = slot_pos_ff[slot_req];
                  end else begin
                     slot_valid_in[slot_req] = 1'b0;
                  end
               end
               bfr_pkg::OP_QUERY: begin
                  avail_in = (len_ff == 13'd0)
                             || ({1'b0, consumed} + {5'd0, count_ff} < {5'd0, len_ff});
               end
               default: begin
               end
            endcase
         end
         bfr_pkg::S_LOAD: begin
            state_in = bfr_pkg::S_BIT;
            if ((op_ff == bfr_pkg::OP_UE || op_ff == bfr_pkg::OP_SE) && !suffix_ff
                && (rd_pos_ff >= bfr_pkg::RPOS_W'(bfr_pkg::BUF_BITS))) begin
               status_in = bfr_pkg::ST_RANGE;
               state_in  = bfr_pkg::S_DONE;
            end
         end
         bfr_pkg::S_BIT: begin
            rd_pos_in = rd_pos_ff + 1'b1;
            state_in  = bfr_pkg::S_LOAD;
            if ((op_ff == bfr_pkg::OP_UE || op_ff == bfr_pkg::OP_SE) && !suffix_ff) begin
               if (!cur_bit) begin
                  zeros_in = zeros_ff + 1'b1;
                  if (zeros_ff == bfr_pkg::ZERO_W'(bfr_pkg::MAX_UE_ZEROS)) begin
                     status_in = bfr_pkg::ST_UE_LONG;
                     state_in  = bfr_pkg::S_DONE;
                  end
               end else begin
                  value_in  = 64'd1;
                  suffix_in = 1'b1;
                  remain_in = 7'(zeros_ff);
                  if (zeros_ff == '0) begin
                     state_in = bfr_pkg::S_FINISH;
                  end else if (21'(rd_pos_ff) + 21'd1 + 21'(zeros_ff)
                               > 21'(bfr_pkg::BUF_BITS)) begin
                     value_in  = '0;
                     status_in = bfr_pkg::ST_RANGE;
                     state_in  = bfr_pkg::S_DONE;
                  end
               end
            end else begin
               remain_in = remain_ff - 7'd1;
               byte_in   = {byte_ff[6:0], cur_bit};
               if (op_ff == bfr_pkg::OP_BYTES && !big_ff) begin
                  if (remain_ff[2:0] == 3'd1) begin
                     value_in = {byte_in, value_ff[63:8]};
                  end
               end else begin
                  value_in = {value_ff[62:0], cur_bit};
               end
               if (remain_ff == 7'd1) begin
                  state_in = (op_ff == bfr_pkg::OP_BYTES && !big_ff && pad_ff != 3'd0)
                             ? bfr_pkg::S_PAD : bfr_pkg::S_FINISH;
               end
            end
         end
         bfr_pkg::S_PAD: begin
            value_in = {8'd0, value_ff[63:8]};
            pad_in   = pad_ff - 3'd1;
            if (pad_ff == 3'd1) begin
               state_in = bfr_pkg::S_FINISH;
            end
         end
         bfr_pkg::S_FINISH: begin
            state_in = bfr_pkg::S_DONE;
            pos_in   = rd_pos_ff[bfr_pkg::POS_W-1:0];
            if (op_ff == bfr_pkg::OP_UE) begin
               value_in = value_ff - 64'd1;
            end else if (op_ff == bfr_pkg::OP_SE) begin
               value_in = value_ff[0] ? (64'd0 - {1'b0, value_ff[63:1]})
                                      : {1'b0, value_ff[63:1]};
            end
         end
         bfr_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bfr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfr_pkg::S_IDLE;
         pos_ff        <= '0;
         next_id_ff    <= '0;
         slot_valid_ff <= '0;
         big_ff        <= 1'b0;
         len_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         next_id_ff    <= next_id_in;
         slot_valid_ff <= slot_valid_in;
         if (csr_we) begin
            priority case (bfr_pkg::csr_type'(csr_index))
               bfr_pkg::CSR_BYTE_ORDER:  big_ff <= csr_wdata[0];
               bfr_pkg::CSR_DATA_LENGTH: len_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (state_ff == bfr_pkg::S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= bfr_pkg::op_type'(req_type);
         count_ff <= req_count;
         addr_ff  <= req_write_address;
         wbyte_ff <= req_write_byte;
         sid_ff   <= req_save_id;
      end
      rd_pos_ff <= rd_pos_in;
      remain_ff <= remain_in;
      zeros_ff  <= zeros_in;
      suffix_ff <= suffix_in;
      pad_ff    <= pad_in;
      byte_ff   <= byte_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      newid_ff  <= newid_in;
      avail_ff  <= avail_in;
      if (slot_we) begin
         slot_pos_ff[slot_save] <= pos_ff;
         slot_id_ff[slot_save]  <= next_id_ff;
      end
      if (state_ff == bfr_pkg::S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_value_ff    <= value_ff;
         rsp_status_ff   <= status_ff;
         rsp_newid_ff    <= newid_ff;
         rsp_consumed_ff <= consumed[15:0];
         rsp_avail_ff    <= avail_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_new_save_id    = rsp_newid_ff;
   assign rsp_consumed_bytes = rsp_consumed_ff;
   assign rsp_available      = rsp_avail_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bfr_pkg::ST_RANGE || rsp_status == bfr_pkg::ST_UE_LONG)
      |-> rsp_value == 64'd0)
      else $error("error word carries nonzero value");
   a_finish_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfr_pkg::S_FINISH |=> state_ff == bfr_pkg::S_DONE)
      else $error("finish not followed by done");
   a_bit_in_buf: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfr_pkg::S_BIT |-> rd_pos_ff < bfr_pkg::RPOS_W'(bfr_pkg::BUF_BITS))
      else $error("bit read beyond buffer");
   a_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfr_pkg::S_BIT |-> remain_ff <= 7'd64)
      else $error("bit count overflow");
endmodule

// File: sim/tb_bitstream_field_reader.sv
// Testbench for bitstream_field_reader: random and directed requests, scoreboard check.
// Depends on bfr_pkg and the bitstream_field_reader RTL.
`timescale 1ns / 1ps

module tb_bitstream_field_reader;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
      logic [15:0] new_id;
      logic [15:0] consumed;
      logic        avail;
   } reply_type;

   class reader_scoreboard;
      logic [7:0]  mem [bfr_pkg::BUF_BYTES];
      logic [15:0] offs;
      logic [2:0]  bidx;
      logic [18:0] slot_pos [bfr_pkg::SAVE_SLOTS];
      logic [15:0] slot_id [bfr_pkg::SAVE_SLOTS];
      logic        slot_ok [bfr_pkg::SAVE_SLOTS];
      logic [15:0] next_id;
      logic        big;
      logic [12:0] dlen;
      reply_type   pending_q[$];
      int          errors;

      function new();
         offs = 0;
         bidx = 0;
         next_id = 0;
         big = 0;
         dlen = 0;
         errors = 0;
         for (int i = 0; i < bfr_pkg::SAVE_SLOTS; i++) slot_ok[i] = 0;
         for (int i = 0; i < bfr_pkg::BUF_BYTES; i++) mem[i] = 0;
      endfunction

      function int pos();
         return {offs, bidx};
      endfunction

      function void set_pos(int p);
         logic [18:0] q;
         q = p[18:0];
         offs = q[18:3];
         bidx = q[2:0];
      endfunction

      function logic [63:0] take(int p, int n);
         logic [63:0] v;
         int b;
         v = 0;
         for (int i = 0; i < n; i++) begin
            b = p + i;
            v = {v[62:0], mem[b >> 3][7 - (b & 7)]};
         end
         return v;
      endfunction

      function logic [1:0] read_golomb(output logic [63:0] k);
         int p, z;
         p = pos();
         z = 0;
         k = 0;
         forever begin
            if (p + 1 > bfr_pkg::BUF_BITS) return bfr_pkg::ST_RANGE;
            if (take(p, 1) == 1) begin
               p++;
               break;
            end
            p++;
            z++;
            if (z > bfr_pkg::MAX_UE_ZEROS) return bfr_pkg::ST_UE_LONG;
         end
         if (p + z > bfr_pkg::BUF_BITS) return bfr_pkg::ST_RANGE;
         k = (64'd1 << z) + take(p, z) - 64'd1;
         set_pos(p + z);
         return bfr_pkg::ST_OK;
      endfunction

      function void write_csr(bfr_pkg::csr_type idx, logic [12:0] val);
         if (idx == bfr_pkg::CSR_BYTE_ORDER) big = val[0];
         else dlen = val;
      endfunction

      function void note_word(logic [3:0] t, logic [12:0] c, logic [11:0] a,
                              logic [7:0] wb, logic [15:0] s);
         reply_type r;
         int p, n, slot, used;
         logic [63:0] k, b;
         r = '0;
         p = pos();
         case (t)
            bfr_pkg::OP_WRITE: mem[a] = wb;
            bfr_pkg::OP_BITS: begin
               n = (c > 64) ? 64 : c;
               if (p + n > bfr_pkg::BUF_BITS) r.status = bfr_pkg::ST_RANGE;
               else begin
                  r.value = take(p, n);
                  set_pos(p + n);
               end
            end
            bfr_pkg::OP_UE, bfr_pkg::OP_SE: begin
               r.status = read_golomb(k);
               if (r.status == bfr_pkg::ST_OK) begin
                  if (t == bfr_pkg::OP_UE) r.value = k;
                  else r.value = k[0] ? (k >> 1) + 64'd1 : 64'd0 - (k >> 1);
               end
            end
            bfr_pkg::OP_ALIGN: if (bidx != 0) set_pos((p & ~7) + 8);
            bfr_pkg::OP_BYTES: begin
               if (c == 1 || c == 2 || c == 4 || c == 8) begin
                  if (p + c * 8 > bfr_pkg::BUF_BITS) r.status = bfr_pkg::ST_RANGE;
                  else begin
                     for (int i = 0; i < c; i++) begin
                        b = take(p + i * 8, 8);
                        if (big) r.value = (r.value << 8) | b;
                        else r.value = r.value | (b << (8 * i));
                     end
                     set_pos(p + c * 8);
                  end
               end
            end
            bfr_pkg::OP_SKIPBITS: set_pos(p + c);
            bfr_pkg::OP_SKIPBYTES: set_pos(p + c * 8);
            bfr_pkg::OP_SAVE: begin
               slot = next_id % bfr_pkg::SAVE_SLOTS;
               slot_pos[slot] = p[18:0];
               slot_id[slot] = next_id;
               slot_ok[slot] = 1;
               r.new_id = next_id;
               next_id = next_id + 16'd1;
            end
            bfr_pkg::OP_RESTORE, bfr_pkg::OP_CLEAR: begin
               slot = s % bfr_pkg::SAVE_SLOTS;
               if (!slot_ok[slot] || slot_id[slot] != s) r.status = bfr_pkg::ST_BAD_ID;
               else if (t == bfr_pkg::OP_RESTORE) set_pos(int'(slot_pos[slot]));
               else slot_ok[slot] = 0;
            end
            bfr_pkg::OP_QUERY: begin
               used = offs + (bidx != 0 ? 1 : 0);
               r.avail = (dlen == 0 || used + c < dlen);
            end
            default: ;
         endcase
         used = offs + (bidx != 0 ? 1 : 0);
         r.consumed = used[15:0];
         pending_q.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch %s: got %h want %h", what, got, want);
      endtask

      task check_word(reply_type got);
         reply_type w;
         if (pending_q.size() == 0) begin
            report("unexpected word", 64'(got.value), 64'd0);
            return;
         end
         w = pending_q.pop_front();
         if (got.value !== w.value) report("value", got.value, w.value);
         if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
         if (got.new_id !== w.new_id) report("new_save_id", 64'(got.new_id), 64'(w.new_id));
         if (got.consumed !== w.consumed)
            report("consumed_bytes", 64'(got.consumed), 64'(w.consumed));
         if (got.avail !== w.avail) report("available", 64'(got.avail), 64'(w.avail));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_type;
   logic [12:0]        req_count;
   logic [11:0]        req_write_address;
   logic [7:0]         req_write_byte;
   logic [15:0]        req_save_id;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [63:0] rsp_value;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_new_save_id;
   logic [15:0]        rsp_consumed_bytes;
   logic               rsp_available;
   logic               csr_we;
   logic               csr_index;
   logic [12:0]        csr_wdata;

   reader_scoreboard sb;
   bit  calm;
   bit  hold_start;
   bit  hold_taken;
   int  hold_left;

   bitstream_field_reader i_dut (.*);

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_left = 0;
         hold_taken = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_word({rsp_value, rsp_status, rsp_new_save_id, rsp_consumed_bytes,
                           rsp_available});
         if (hold_start && !hold_taken) begin
            hold_left = 400;
            hold_taken = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= calm || $urandom_range(0, 99) >= 24;
         end
      end
   end

   task automatic send(logic [3:0] t, logic [12:0] c, logic [11:0] a, logic [7:0] wb,
                       logic [15:0] s);
      if (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= t;
      req_count <= c;
      req_write_address <= a;
      req_write_byte <= wb;
      req_save_id <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_word(t, c, a, wb, s);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_csr(bfr_pkg::csr_type idx, logic [12:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_csr(idx, val);
      csr_we <= 0;
   endtask

   task automatic op(logic [3:0] t, logic [12:0] c = 0, logic [15:0] s = 0);
      send(t, c, 12'($urandom), 8'($urandom), s);
   endtask

   // walk the position forward past the 2^19 bit wrap back to the buffer start
   task automatic rewind();
      int remaining;
      int step;
      remaining = 65536 - int'(sb.offs);
      while (remaining > 0) begin
         step = (remaining > 8191) ? 8191 : remaining;
         op(bfr_pkg::OP_SKIPBYTES, 13'(step));
         remaining -= step;
      end
   endtask

   task automatic random_word();
      int pick;
      logic [15:0] id;
      pick = $urandom_range(0, 99);
      id = sb.next_id - 16'd1 - 16'($urandom_range(0, 20));
      if ($urandom_range(0, 9) == 0) id = 16'($urandom);
      if (pick < 10) send(bfr_pkg::OP_WRITE, 13'($urandom), 12'($urandom), 8'($urandom),
                          16'($urandom));
      else if (pick < 13) send(bfr_pkg::OP_WRITE, 13'd0, 12'($urandom_range(0, 300)),
                               8'h00, 16'd0);
      else if (pick < 28) op(bfr_pkg::OP_BITS, ($urandom_range(0, 19) == 0) ?
                             13'($urandom) : 13'($urandom_range(0, 64)));
      else if (pick < 40) op(bfr_pkg::OP_UE);
      else if (pick < 50) op(bfr_pkg::OP_SE);
      else if (pick < 54) op(bfr_pkg::OP_ALIGN);
      else if (pick < 64) op(bfr_pkg::OP_BYTES, ($urandom_range(0, 9) == 0) ?
                             13'($urandom) : 13'(1 << $urandom_range(0, 3)));
      else if (pick < 69) op(bfr_pkg::OP_SKIPBITS, ($urandom_range(0, 19) == 0) ?
                             13'($urandom) : 13'($urandom_range(0, 40)));
      else if (pick < 73) op(bfr_pkg::OP_SKIPBYTES, ($urandom_range(0, 19) == 0) ?
                             13'($urandom) : 13'($urandom_range(0, 8)));
      else if (pick < 81) op(bfr_pkg::OP_SAVE);
      else if (pick < 89) op(bfr_pkg::OP_RESTORE, 13'd0, id);
      else if (pick < 93) op(bfr_pkg::OP_CLEAR, 13'd0, id);
      else if (pick < 98) op(bfr_pkg::OP_QUERY, 13'($urandom));
      else op(4'($urandom_range(12, 15)), 13'($urandom), 16'($urandom));
      // reads stay inside the filled bytes at the start of the buffer
      if (sb.offs > 16'd182) rewind();
   endtask

   initial begin
      sb = new();
      calm = 0;
      hold_start = 0;
      reset = 1;
      req_valid = 0;
      req_type = bfr_pkg::OP_WRITE;
      req_count = 0;
      req_write_address = 0;
      req_write_byte = 0;
      req_save_id = 0;
      csr_we = 0;
      csr_index = bfr_pkg::CSR_BYTE_ORDER;
      csr_wdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      set_csr(bfr_pkg::CSR_BYTE_ORDER, 13'd1);
      set_csr(bfr_pkg::CSR_DATA_LENGTH, 13'd4096);
      // fill the buffer start and its last bytes; reads never reach the rest
      for (int a = 0; a < 192; a++)
         send(bfr_pkg::OP_WRITE, 13'($urandom), 12'(a), 8'($urandom), 16'($urandom));
      for (int a = bfr_pkg::BUF_BYTES - 32; a < bfr_pkg::BUF_BYTES; a++)
         send(bfr_pkg::OP_WRITE, 13'($urandom), 12'(a), 8'($urandom), 16'($urandom));

      // leading zero runs for an over-long and the longest legal ue
      for (int a = 0; a < 5; a++) send(bfr_pkg::OP_WRITE, 13'd0, 12'(a), 8'h00, 16'd0);
      send(bfr_pkg::OP_WRITE, 13'd0, 12'd5, 8'h80, 16'd0);
      op(bfr_pkg::OP_UE);
      op(bfr_pkg::OP_SKIPBITS, 13'd9);
      op(bfr_pkg::OP_UE);
      op(bfr_pkg::OP_SE);
      op(bfr_pkg::OP_BITS, 13'd64);
      op(bfr_pkg::OP_BITS, 13'd0);
      op(bfr_pkg::OP_BITS, 13'd8191);
      op(bfr_pkg::OP_BYTES, 13'd1);
      op(bfr_pkg::OP_BYTES, 13'd2);
      op(bfr_pkg::OP_BYTES, 13'd4);
      op(bfr_pkg::OP_BYTES, 13'd8);
      op(bfr_pkg::OP_BYTES, 13'd3);
      op(bfr_pkg::OP_SKIPBITS, 13'd3);
      op(bfr_pkg::OP_ALIGN);
      op(bfr_pkg::OP_SAVE);
      op(bfr_pkg::OP_RESTORE, 13'd0, 16'd0);
      op(bfr_pkg::OP_CLEAR, 13'd0, 16'd0);
      op(bfr_pkg::OP_CLEAR, 13'd0, 16'd0);
      op(bfr_pkg::OP_QUERY, 13'd8191);
      op(4'd15, 13'd8191, 16'hFFFF);
      send(bfr_pkg::OP_WRITE, 13'd0, 12'hFFF, 8'hFF, 16'd0);
      // reads at the end of the buffer
      rewind();
      op(bfr_pkg::OP_ALIGN);
      op(bfr_pkg::OP_SKIPBYTES, 13'd4090);
      op(bfr_pkg::OP_BYTES, 13'd8);
      op(bfr_pkg::OP_BITS, 13'd48);
      op(bfr_pkg::OP_UE);
      rewind();

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         set_csr(bfr_pkg::CSR_BYTE_ORDER, 13'(ph & 1));
         case (ph)
            0: set_csr(bfr_pkg::CSR_DATA_LENGTH, 13'd0);
            1: set_csr(bfr_pkg::CSR_DATA_LENGTH, 13'($urandom_range(1, 4095)));
            2: set_csr(bfr_pkg::CSR_DATA_LENGTH, 13'd1);
            default: set_csr(bfr_pkg::CSR_DATA_LENGTH, 13'd4096);
         endcase
         calm = (ph == 1);
         if (ph == 2) hold_start = 1;
         for (int i = 0; i < 105; i++) random_word();
      end

      calm = 0;
      drain();
      if (sb.errors == 0 && sb.pending_q.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #200ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: bitstream_field_reader.f
rtl/core/bfr_pkg.sv
rtl/core/bfr_ram.sv
rtl/core/bitstream_field_reader.sv
sim/tb_bitstream_field_reader.sv
